// ===== rtl/core/slrg_pkg.sv =====
// Shared types, constants and an arithmetic helper for the subtractive lagged generator.
package slrg_pkg;

    localparam int unsigned VALUE_W = 30;
    localparam int unsigned SEED_W  = 28;
    localparam int unsigned IDX_W   = 6;

    localparam logic [VALUE_W-1:0] MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0]  SEED_BASE = 28'd161803398;

    // Table geometry: positions 1..55 live in slots 0..54.
    localparam logic [IDX_W-1:0] TABLE_LEN  = 6'd55;
    localparam logic [IDX_W-1:0] LAST_SLOT  = 6'd54;
    localparam logic [IDX_W-1:0] STRIDE     = 6'd21;
    localparam logic [IDX_W-1:0] FIRST_FILL = 6'd20;
    localparam logic [IDX_W-1:0] FILL_LAST  = 6'd53;
    localparam logic [IDX_W-1:0] LAG_START  = 6'd31;
    localparam logic [1:0]       PASS_LAST  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TOP,
        OP_FILL,
        OP_MIX_RD,
        OP_MIX_WR,
        OP_DRAW_RD,
        OP_DRAW_WR
    } mem_op_t;

    typedef struct packed {
        logic    load;
        mem_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic mix_last;
    } dp_sts_t;

    // Difference modulo one billion of two values that are both below the modulus.
    function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] d;
        logic [VALUE_W:0] w;
        d = {1'b0, a} - {1'b0, b};
        w = d + {1'b0, MODULUS};
        return d[VALUE_W] ? w[VALUE_W-1:0] : d[VALUE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/subtractive_lagged_random_generator_top.sv =====
// Top level of the subtractive lagged random generator: controller plus datapath.
// Draw: after acceptance the table is read into the registered read ports; once the output
// register is free or being emptied, the difference is written back and made the result.
// The next request can be taken alongside that write-back. Reseed (or first request after
// reset): 1 + 54 table fill writes, 4 x 55 mixing steps (read, write-back), then the draw.
// Reset (aresetn, synchronous, active low) clears the controller, the output valid, the
// seeded flag and the read indices; the table holds nothing meaningful until rebuilt.
module subtractive_lagged_random_generator_top
    import slrg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [SEED_W-1:0]   s_seed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_value
);

    // The controller decides, for each accepted request, whether the table must be
    // rebuilt. A rebuild happens on a reseed command and on the very first request
    // after reset, since the table is never read before it has been written.
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Sequencer: walks through the fill, the mixing passes and the draw, and holds the
    // result valid flag. A new request is taken in the same cycle as the write-back of
    // the previous draw, provided the output register is free or being emptied.
    slrg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    // Datapath: the 55-word table memory with two registered read ports and one write
    // port, the rebuild recurrence registers, the two wrapping indices and the result
    // register. The seed is sampled directly from the port in the cycle of acceptance.
    slrg_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dp_cmd),
        .s_seed  (s_seed),
        .sts     (dp_sts),
        .m_value (m_value)
    );

endmodule

// ===== rtl/core/slrg_dp.sv =====
// Datapath: lag table memory, rebuild registers, read indices and result register.
module slrg_dp
    import slrg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic [SEED_W-1:0]   s_seed,
    output dp_sts_t             sts,
    output logic [VALUE_W-1:0]  m_value
);

    logic [VALUE_W-1:0] mem [0:54];

    logic [VALUE_W-1:0] cur_reg;
    logic [VALUE_W-1:0] nxt_reg;
    logic [IDX_W-1:0]   fill_slot_reg;
    logic [IDX_W-1:0]   fill_cnt_reg;
    logic [IDX_W-1:0]   mix_slot_reg;
    logic [1:0]         pass_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   second_reg;
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [SEED_W-1:0]  seed_dist;
    logic [IDX_W:0]     fill_sum;
    logic [IDX_W-1:0]   fill_slot_next;
    logic [IDX_W:0]     mix_sum;
    logic [IDX_W-1:0]   mix_b_slot;
    logic [IDX_W-1:0]   first_slot;
    logic [IDX_W-1:0]   second_slot;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] diff;

    always_comb begin
        seed_dist = (s_seed > SEED_BASE) ? (s_seed - SEED_BASE) : (SEED_BASE - s_seed);

        // Stride-21 walk over the slots; the wrap case past the last step is never used.
        fill_sum = {1'b0, fill_slot_reg} + {1'b0, STRIDE};
        fill_slot_next = (fill_sum >= {1'b0, LAST_SLOT}) ? fill_sum[IDX_W-1:0] - TABLE_LEN
                                                         : fill_sum[IDX_W-1:0];

        mix_sum = {1'b0, mix_slot_reg} + {1'b0, LAG_START};
        mix_b_slot = (mix_sum >= {1'b0, TABLE_LEN}) ? mix_sum[IDX_W-1:0] - TABLE_LEN
                                                    : mix_sum[IDX_W-1:0];

        // Slot of the advanced index: position 55 (or anything out of range) wraps to slot 0.
        first_slot  = (first_reg  >= TABLE_LEN) ? '0 : first_reg;
        second_slot = (second_reg >= TABLE_LEN) ? '0 : second_reg;

        rd_en     = (cmd.op == OP_MIX_RD) || (cmd.op == OP_DRAW_RD);
        rd_addr_a = (cmd.op == OP_MIX_RD) ? mix_slot_reg : first_slot;
        rd_addr_b = (cmd.op == OP_MIX_RD) ? mix_b_slot   : second_slot;

        diff = sub_mod(rd_a_reg, rd_b_reg);

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (cmd.op)
            OP_TOP: begin
                wr_en   = 1'b1;
                wr_addr = LAST_SLOT;
                wr_data = cur_reg;
            end
            OP_FILL: begin
                wr_en   = 1'b1;
                wr_addr = fill_slot_reg;
                wr_data = nxt_reg;
            end
            OP_MIX_WR: begin
                wr_en   = 1'b1;
                wr_addr = mix_slot_reg;
                wr_data = diff;
            end
            OP_DRAW_WR: begin
                wr_en   = 1'b1;
                wr_addr = first_reg - 6'd1;
                wr_data = diff;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg       <= {{(VALUE_W-SEED_W){1'b0}}, seed_dist};
            nxt_reg       <= 30'd1;
            fill_slot_reg <= FIRST_FILL;
            fill_cnt_reg  <= '0;
            mix_slot_reg  <= '0;
            pass_reg      <= '0;
        end
        case (cmd.op)
            OP_FILL: begin
                nxt_reg       <= sub_mod(cur_reg, nxt_reg);
                cur_reg       <= nxt_reg;
                fill_slot_reg <= fill_slot_next;
                fill_cnt_reg  <= fill_cnt_reg + 6'd1;
            end
            OP_MIX_WR: begin
                if (mix_slot_reg == LAST_SLOT) begin
                    mix_slot_reg <= '0;
                    pass_reg     <= pass_reg + 2'd1;
                end else begin
                    mix_slot_reg <= mix_slot_reg + 6'd1;
                end
            end
            OP_DRAW_WR: begin
                value_reg <= diff;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= LAG_START;
        end else if (cmd.load) begin
            first_reg  <= '0;
            second_reg <= LAG_START;
        end else if (cmd.op == OP_DRAW_RD) begin
            first_reg  <= first_slot + 6'd1;
            second_reg <= second_slot + 6'd1;
        end
    end

    assign sts.fill_last = (fill_cnt_reg == FILL_LAST);
    assign sts.mix_last  = (mix_slot_reg == LAST_SLOT) && (pass_reg == PASS_LAST);
    assign m_value       = value_reg;

endmodule

// ===== rtl/core/slrg_ctrl.sv =====
// Controller: sequences reseeding, mixing and draws, and owns both handshakes.
module slrg_ctrl
    import slrg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_command,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_DRAW_RD,
        ST_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   seeded_reg, seeded_next;
    logic   out_free;
    logic   rebuild;

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        rebuild      = s_command || !seeded_reg;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        seeded_next  = seeded_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.op       = OP_NONE;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load    = rebuild;
                    seeded_next = 1'b1;
                    state_next  = rebuild ? ST_TOP : ST_DRAW_RD;
                end
            end
            ST_TOP: begin
                cmd.op     = OP_TOP;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd.op = OP_FILL;
                if (sts.fill_last) begin
                    state_next = ST_MIX_RD;
                end
            end
            ST_MIX_RD: begin
                cmd.op     = OP_MIX_RD;
                state_next = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                cmd.op     = OP_MIX_WR;
                state_next = sts.mix_last ? ST_DRAW_RD : ST_MIX_RD;
            end
            ST_DRAW_RD: begin
                cmd.op     = OP_DRAW_RD;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    cmd.op       = OP_DRAW_WR;
                    m_valid_next = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load    = rebuild;
                        seeded_next = 1'b1;
                        state_next  = rebuild ? ST_TOP : ST_DRAW_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            seeded_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            seeded_reg  <= seeded_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/slrg_checker.sv =====
// Port-level checker for the subtractive lagged random generator, with its bind.
module slrg_checker
    import slrg_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [VALUE_W-1:0] m_value
);

    // A result waiting to be taken keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value)))
        else $error("result changed while stalled");

    // Every value lies below one billion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value < MODULUS))
        else $error("value out of range");

    // The cycle after a request is accepted the block is busy with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one still at work");

    // The cycle after acceptance only reads the table or starts the rebuild, so no
    // new result can be raised during it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind subtractive_lagged_random_generator_top slrg_checker u_slrg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_value   (m_value)
);

// ===== verif/subtractive_lagged_random_generator_top_tb.sv =====
// Self-checking testbench for the subtractive lagged random generator top level.
`timescale 1ns / 100ps

module subtractive_lagged_random_generator_top_tb;
    import slrg_pkg::*;

    // The command bit of a request: draw the next value, or rebuild the table first.
    typedef enum logic {
        CMD_DRAW   = 1'b0,
        CMD_RESEED = 1'b1
    } request_cmd_t;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 600;
    // A rebuild has nothing moving for its whole length; add the long receiver
    // hold-off and the longest sender gap, then allow several times that.
    localparam int IDLE_LIMIT    = 5000;
    // The hold-off outlasts a whole rebuild, so the block is sure to back up.
    localparam int LONG_HOLD     = 1000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PRINT_CAP     = 100;

    // Scoreboard: keeps its own copy of the 55-word lag table and both read
    // positions, works out the value that each accepted request must produce and
    // checks the results in order against it.
    class lagged_draw_scoreboard;
        localparam int TABLE_SLOTS = int'(TABLE_LEN);
        localparam int FILL_STRIDE = int'(STRIDE);
        localparam int TRAIL_START = int'(LAG_START);
        localparam int LAG_SPAN    = 30;
        localparam int MOD_INT     = int'(MODULUS);

        logic [VALUE_W-1:0] lag_words [TABLE_SLOTS];
        int unsigned        lead_pos;
        int unsigned        trail_pos;
        bit                 primed;
        logic [VALUE_W-1:0] expected_draws [$];
        int unsigned        mismatches;

        function new();
            foreach (lag_words[k]) lag_words[k] = '0;
            lead_pos   = 0;
            trail_pos  = TRAIL_START;
            primed     = 1'b0;
            mismatches = 0;
        endfunction

        static function logic [VALUE_W-1:0] mod_diff(logic [VALUE_W-1:0] a,
                                                     logic [VALUE_W-1:0] b);
            int diff;
            diff = int'(a) - int'(b);
            if (diff < 0) diff += MOD_INT;
            return diff[VALUE_W-1:0];
        endfunction

        static function int unsigned step_pos(int unsigned pos);
            pos++;
            if (pos < 1 || pos > TABLE_SLOTS) pos = 1;
            return pos;
        endfunction

        function void rebuild_table(logic [SEED_W-1:0] seed);
            int                 start;
            int unsigned        slot;
            int unsigned        partner;
            logic [VALUE_W-1:0] prev_word;
            logic [VALUE_W-1:0] next_word;
            start = int'(SEED_BASE) - int'(seed);
            if (start < 0) start = -start;
            start = start % MOD_INT;
            prev_word = start[VALUE_W-1:0];
            next_word = 1;
            lag_words[TABLE_SLOTS-1] = prev_word;
            for (int i = 1; i < TABLE_SLOTS; i++) begin
                slot = (FILL_STRIDE * i) % TABLE_SLOTS;
                lag_words[slot-1] = next_word;
                next_word = mod_diff(prev_word, next_word);
                prev_word = lag_words[slot-1];
            end
            for (int pass = 0; pass < 4; pass++) begin
                for (int i = 1; i <= TABLE_SLOTS; i++) begin
                    partner = 1 + (i + LAG_SPAN) % TABLE_SLOTS;
                    lag_words[i-1] = mod_diff(lag_words[i-1], lag_words[partner-1]);
                end
            end
            lead_pos  = 0;
            trail_pos = TRAIL_START;
            primed    = 1'b1;
        endfunction

        function void note_request(request_cmd_t cmd, logic [SEED_W-1:0] seed);
            logic [VALUE_W-1:0] draw;
            if (cmd == CMD_RESEED || !primed) rebuild_table(seed);
            lead_pos  = step_pos(lead_pos);
            trail_pos = step_pos(trail_pos);
            draw = mod_diff(lag_words[lead_pos-1], lag_words[trail_pos-1]);
            lag_words[lead_pos-1] = draw;
            expected_draws.push_back(draw);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        task check_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] want;
            if (expected_draws.size() == 0) begin
                report_mismatch($sformatf("value %0d arrived with nothing outstanding",
                                          value));
            end else begin
                want = expected_draws.pop_front();
                if (value !== want)
                    report_mismatch($sformatf("value %0d, expected %0d", value, want));
            end
        endtask

        function int unsigned outstanding();
            return expected_draws.size();
        endfunction
    endclass

    // Every input starts at a known value; the clock idles low.
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic               s_command = CMD_DRAW;
    logic [SEED_W-1:0]  s_seed    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [VALUE_W-1:0] m_value;

    lagged_draw_scoreboard ledger = new();

    int unsigned burst_left  = 0;
    int unsigned items_sent  = 0;
    int unsigned idle_run    = 0;
    bit          hold_off_req = 1'b0;

    subtractive_lagged_random_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_seed    (s_seed),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value)
    );

    always begin : clock_gen
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Both handshakes are observed at the rising edge, where the values seen are
    // the ones the block itself registered on. A result is checked before the
    // request of the same edge is noted, since it cannot belong to that request.
    always @(posedge aclk) begin : handshake_monitor
        if (aresetn) begin
            if (m_valid && m_ready) ledger.check_value(m_value);
            if (s_valid && s_ready) ledger.note_request(request_cmd_t'(s_command), s_seed);
        end
    end

    // The watchdog ends the run if no request and no result moves for too long.
    // The long receiver hold-off is the longest quiet stretch, and it is well inside the limit.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("[%0t] Timeout: nothing accepted for %0d cycles", $time, idle_run);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver switches between stall patterns of its own, each held for a
    // random run of cycles: always ready, a coin toss, mostly ready and mostly
    // stalled. When the stimulus asks for it, it also holds off once for a long
    // stretch so that results back up and the block stops taking requests.
    initial begin : result_sink
        int unsigned mode;
        int unsigned run;
        bit          held;
        held = 1'b0;
        forever begin
            if (hold_off_req && !held) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(10, 80);
            for (int k = 0; k < run; k++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Present one request and hold it, unchanged, until the block takes it.
    // Returns at the edge on which the request was accepted.
    task automatic send_request(input request_cmd_t cmd, input logic [SEED_W-1:0] seed);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_seed    <= seed;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // The sender works in bursts of random length. Between bursts it may drop
    // valid for a gap, usually short and now and then long; some bursts follow
    // straight on so that long stretches see no gap at all.
    task automatic offer(input request_cmd_t cmd, input logic [SEED_W-1:0] seed);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        send_request(cmd, seed);
    endtask

    // Stop offering and wait until every expected value has been returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (ledger.outstanding() != 0);
    endtask

    // Seeds lean towards the interesting places: inside the stated range, right
    // around the base constant (a zero starting word), the all-zero and all-one
    // patterns, small values and anything the 28 bits can hold.
    function automatic logic [SEED_W-1:0] random_seed();
        logic [SEED_W-1:0] pick;
        case ($urandom_range(0, 5))
            0: pick = SEED_W'($urandom_range(0, int'(SEED_BASE)));
            1: pick = SEED_BASE - SEED_W'(2) + SEED_W'($urandom_range(0, 4));
            2: pick = $urandom_range(0, 1) ? '1 : '0;
            3: pick = SEED_W'($urandom_range(0, 255));
            default: pick = SEED_W'($urandom());
        endcase
        return pick;
    endfunction

    initial begin : stimulus
        int unsigned draws;
        int unsigned sequence_no;
        bit          paused_mid;

        // Reset is held for a fixed number of cycles, once, at the start.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The very first request is a plain draw, which must still
        // build the table, here from a seed above the stated range.
        offer(CMD_DRAW, '1);
        // Once seeded, the seed field of a draw must be ignored.
        offer(CMD_DRAW, '0);
        offer(CMD_DRAW, SEED_BASE);
        // Reseeding while seeded, from the all-zero seed, then a draw with an all-one seed.
        offer(CMD_RESEED, '0);
        offer(CMD_DRAW, '1);
        // A seed equal to the base constant gives a zero starting word.
        offer(CMD_RESEED, SEED_BASE);
        offer(CMD_DRAW, '0);
        // Back-to-back reseeds on either side of the base constant.
        offer(CMD_RESEED, SEED_BASE + SEED_W'(1));
        offer(CMD_RESEED, SEED_BASE - SEED_W'(1));
        offer(CMD_RESEED, SEED_W'(1));
        offer(CMD_RESEED, '1);
        for (int k = 0; k < 10; k++)
            offer(CMD_DRAW, (k % 2 == 0) ? SEED_W'(28'h5555555) : SEED_W'(28'hAAAAAAA));
        offer(CMD_RESEED, SEED_W'(28'hAAAAAAA));
        offer(CMD_DRAW, SEED_W'(28'h5555555));
        offer(CMD_DRAW, '1);

        // The sender pauses here until everything outstanding has come back.
        drain_results();

        // Random part: mostly a reseed followed by a run of draws, long enough
        // in most cases for both read positions to wrap past the end of the
        // table; now and then a very short run so that reseeds come close
        // together. Draws carry random seeds, which the block must ignore.
        items_sent  = 0;
        sequence_no = 0;
        paused_mid  = 1'b0;
        while (items_sent < RANDOM_ITEMS) begin
            offer(CMD_RESEED, random_seed());
            if ($urandom_range(0, 4) == 0)
                draws = $urandom_range(0, 3);
            else
                draws = $urandom_range(20, 130);
            // Early on, ask the receiver for its long hold-off while requests keep
            // coming, so the block backs up and stalls its input.
            if (sequence_no == 1) hold_off_req = 1'b1;
            for (int k = 0; k < draws && items_sent < RANDOM_ITEMS; k++)
                offer(CMD_DRAW, SEED_W'($urandom()));
            if (!paused_mid && items_sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused_mid = 1'b1;
            end
            sequence_no++;
        end

        // Wait for the last results, then give the block a little longer so that
        // any stray result would still be caught.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (ledger.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
